// ===== hdl/mcn_pkg.sv =====
package mcn_pkg;

  // channel order inside the shared divider sequence
  localparam int unsigned NUM_CH = 3;
  localparam int unsigned CH_W   = 2;

  localparam logic [CH_W-1:0] CH_PEDAL = 2'd0;
  localparam logic [CH_W-1:0] CH_LEFT  = 2'd1;
  localparam logic [CH_W-1:0] CH_RIGHT = 2'd2;

  typedef logic [CH_W-1:0] ch_idx_t;

endpackage

// ===== hdl/mcn_ifs.sv =====
interface mcn_in_if #(
  parameter int unsigned PEDAL_BITS = 12,
  parameter int unsigned FORCE_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic                         calibrate;
  logic        [PEDAL_BITS-1:0] pedal_raw;
  logic signed [FORCE_BITS-1:0] left_force_raw;
  logic signed [FORCE_BITS-1:0] right_force_raw;

  modport source (
    output valid, calibrate, pedal_raw, left_force_raw, right_force_raw,
    input  ready
  );
  modport sink (
    input  valid, calibrate, pedal_raw, left_force_raw, right_force_raw,
    output ready
  );
endinterface

interface mcn_out_if #(
  parameter int unsigned FRAC_BITS = 16
) ();
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] pedal_level;
  logic [FRAC_BITS:0] left_level;
  logic [FRAC_BITS:0] right_level;

  modport source (
    output valid, pedal_level, left_level, right_level,
    input  ready
  );
  modport sink (
    input  valid, pedal_level, left_level, right_level,
    output ready
  );
endinterface

// ===== hdl/minmax_calibrated_normalizer.sv =====
// calibrate transfer: extremes update at the accepting edge, ready stays high
// measure transfer: three channels in turn through one restoring divider, each through
//   S_LOAD, S_CHECK and S_DIV (S_DIV skipped when the level is 0 or 1); the result is
//   held in S_FIN while the previous result waits; the next item is taken once the
//   sequence is back in idle
// asynchronous active-low reset: extremes to the empty range, sequencer idle, no result
module minmax_calibrated_normalizer
  import mcn_pkg::*;
#(
  parameter int unsigned PEDAL_BITS = 12,
  parameter int unsigned FORCE_BITS = 24,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mcn_in_if.sink    in_i,
  mcn_out_if.source out_o
);

  // common signed width for differences of any channel
  localparam int unsigned SW = (PEDAL_BITS + 1 > FORCE_BITS) ? PEDAL_BITS + 1 : FORCE_BITS;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned CW = $clog2(FRAC_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [FRAC_BITS:0] LVL_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] LVL_ZERO = '0;

  localparam logic signed [FORCE_BITS-1:0] FORCE_MAX = {1'b0, {(FORCE_BITS-1){1'b1}}};
  localparam logic signed [FORCE_BITS-1:0] FORCE_MIN = {1'b1, {(FORCE_BITS-1){1'b0}}};

  logic [2:0] state_q, state_d;
  ch_idx_t    ch_q, ch_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // running extremes
  logic        [PEDAL_BITS-1:0] pedal_lo_q, pedal_hi_q;
  logic signed [FORCE_BITS-1:0] left_lo_q, left_hi_q, right_lo_q, right_hi_q;

  // captured samples of the item in work
  logic        [PEDAL_BITS-1:0] pedal_s_q;
  logic signed [FORCE_BITS-1:0] left_s_q, right_s_q;

  // divider datapath
  logic signed [DW-1:0] num_q, num_d, den_q, den_d;
  logic [DW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [FRAC_BITS-1:0] quo_q, quo_d;

  logic [FRAC_BITS:0] lvl_q [NUM_CH];
  logic [FRAC_BITS:0] out_pedal_q, out_left_q, out_right_q;
  logic out_valid_q, out_valid_d;

  logic in_xfer, cal_xfer, meas_xfer, out_load;

  logic signed [DW-1:0] s_sel, lo_sel, hi_sel;
  logic [DW-1:0] mag_n, mag_d;
  logic [DW:0]   r2;
  logic          r_ge;
  logic          lvl_we;
  logic [FRAC_BITS:0] lvl_raw, lvl_wval;
  logic          ch_last;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign cal_xfer   = in_xfer && in_i.calibrate;
  assign meas_xfer  = in_xfer && !in_i.calibrate;
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  assign out_o.valid       = out_valid_q;
  assign out_o.pedal_level = out_pedal_q;
  assign out_o.left_level  = out_left_q;
  assign out_o.right_level = out_right_q;

  // operand select for the channel in work
  always_comb begin
    case (ch_q)
      CH_PEDAL: begin
        s_sel  = {{(DW-PEDAL_BITS){1'b0}}, pedal_s_q};
        lo_sel = {{(DW-PEDAL_BITS){1'b0}}, pedal_lo_q};
        hi_sel = {{(DW-PEDAL_BITS){1'b0}}, pedal_hi_q};
      end
      CH_LEFT: begin
        s_sel  = {{(DW-FORCE_BITS){left_s_q[FORCE_BITS-1]}}, left_s_q};
        lo_sel = {{(DW-FORCE_BITS){left_lo_q[FORCE_BITS-1]}}, left_lo_q};
        hi_sel = {{(DW-FORCE_BITS){left_hi_q[FORCE_BITS-1]}}, left_hi_q};
      end
      default: begin
        s_sel  = {{(DW-FORCE_BITS){right_s_q[FORCE_BITS-1]}}, right_s_q};
        lo_sel = {{(DW-FORCE_BITS){right_lo_q[FORCE_BITS-1]}}, right_lo_q};
        hi_sel = {{(DW-FORCE_BITS){right_hi_q[FORCE_BITS-1]}}, right_hi_q};
      end
    endcase
  end

  assign mag_n = num_q[DW-1] ? DW'(-num_q) : DW'(num_q);
  assign mag_d = den_q[DW-1] ? DW'(-den_q) : DW'(den_q);

  // one restoring step
  assign r2   = {rem_q, 1'b0};
  assign r_ge = (r2 >= {1'b0, dvs_q});

  assign ch_last = (ch_q == CH_RIGHT);

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    den_d       = den_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    out_valid_d = out_valid_q;
    lvl_we      = 1'b0;
    lvl_raw     = LVL_ZERO;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (meas_xfer) begin
          ch_d    = CH_PEDAL;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        num_d   = s_sel - lo_sel;
        den_d   = hi_sel - lo_sel;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // equal extremes, zero numerator or opposite signs give zero
        if ((den_q == '0) || (num_q == '0) || (num_q[DW-1] != den_q[DW-1])) begin
          lvl_we  = 1'b1;
          lvl_raw = LVL_ZERO;
        end else if (mag_n >= mag_d) begin
          lvl_we  = 1'b1;
          lvl_raw = LVL_ONE;
        end else begin
          rem_d   = mag_n;
          dvs_d   = mag_d;
          quo_d   = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
        if (lvl_we) begin
          if (ch_last) begin
            state_d = S_FIN;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = S_LOAD;
          end
        end
      end
      S_DIV: begin
        if (r_ge) begin
          rem_d = DW'(r2 - {1'b0, dvs_q});
        end else begin
          rem_d = DW'(r2);
        end
        quo_d = {quo_q[FRAC_BITS-2:0], r_ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(FRAC_BITS - 1)) begin
          lvl_we  = 1'b1;
          lvl_raw = {1'b0, quo_d};
          if (ch_last) begin
            state_d = S_FIN;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = S_LOAD;
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // pedal level is inverted
  assign lvl_wval = (ch_q == CH_PEDAL) ? (LVL_ONE - lvl_raw) : lvl_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= CH_PEDAL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      pedal_lo_q  <= '1;
      pedal_hi_q  <= '0;
      left_lo_q   <= FORCE_MAX;
      left_hi_q   <= FORCE_MIN;
      right_lo_q  <= FORCE_MAX;
      right_hi_q  <= FORCE_MIN;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cal_xfer) begin
        if (in_i.pedal_raw < pedal_lo_q) pedal_lo_q <= in_i.pedal_raw;
        if (in_i.pedal_raw > pedal_hi_q) pedal_hi_q <= in_i.pedal_raw;
        if (in_i.left_force_raw < left_lo_q) left_lo_q <= in_i.left_force_raw;
        if (in_i.left_force_raw > left_hi_q) left_hi_q <= in_i.left_force_raw;
        if (in_i.right_force_raw < right_lo_q) right_lo_q <= in_i.right_force_raw;
        if (in_i.right_force_raw > right_hi_q) right_hi_q <= in_i.right_force_raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_xfer) begin
      pedal_s_q <= in_i.pedal_raw;
      left_s_q  <= in_i.left_force_raw;
      right_s_q <= in_i.right_force_raw;
    end
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    if (lvl_we) begin
      lvl_q[ch_q] <= lvl_wval;
    end
    if (out_load) begin
      out_pedal_q <= lvl_q[CH_PEDAL];
      out_left_q  <= lvl_q[CH_LEFT];
      out_right_q <= lvl_q[CH_RIGHT];
    end
  end

endmodule
